### src/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, character codes and the byte classifier of the bracket
// balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam logic [7:0] CHAR_BRACE_OPEN   = 8'h7B;  // {
    localparam logic [7:0] CHAR_BRACE_CLOSE  = 8'h7D;  // }
    localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;  // ]
    localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;  // (
    localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;  // )

    typedef enum logic [1:0] {
        KIND_BRACE  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_ROUND  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_UNBALANCED = 2'd0,
        VERDICT_BALANCED   = 2'd1,
        VERDICT_OVERFLOW   = 2'd2
    } verdict_t;

    // Classified byte as it travels from the front to the back
    typedef struct packed {
        logic  is_bracket;
        logic  closing;
        kind_t kind;
        logic  last;
    } item_t;

    function automatic item_t classify(input logic [7:0] c, input logic last);
        item_t it;
        it.is_bracket = 1'b1;
        it.closing    = 1'b0;
        it.kind       = KIND_NONE;
        it.last       = last;
        case (c)
            CHAR_BRACE_OPEN: begin
                it.kind = KIND_BRACE;
            end
            CHAR_BRACE_CLOSE: begin
                it.kind    = KIND_BRACE;
                it.closing = 1'b1;
            end
            CHAR_SQUARE_OPEN: begin
                it.kind = KIND_SQUARE;
            end
            CHAR_SQUARE_CLOSE: begin
                it.kind    = KIND_SQUARE;
                it.closing = 1'b1;
            end
            CHAR_ROUND_OPEN: begin
                it.kind = KIND_ROUND;
            end
            CHAR_ROUND_CLOSE: begin
                it.kind    = KIND_ROUND;
                it.closing = 1'b1;
            end
            default: begin
                it.is_bracket = 1'b0;
            end
        endcase
        return it;
    endfunction

endpackage
`default_nettype wire

### src/bbc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_front
// Accepts input bytes, classifies them and queues bracket bytes and
// end-of-string markers in a two-entry queue for the stack engine.
// ----------------------------------------------------------------------------
module bbc_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [7:0]        s_tdata,   // [7:0] char_code
    input  wire               s_tlast,
    output logic              q_valid,
    input  wire               q_ready,
    output bbc_pkg::item_t    q_item
);
    import bbc_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       item_in;
    logic        push;
    logic        pop;

    assign item_in  = classify(s_tdata, s_tlast);
    assign s_tready = (count_reg != 2'd2);
    // drop plain text bytes that do not end a string
    assign push     = s_tvalid && s_tready && (item_in.is_bracket || item_in.last);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers inconsistent with count");

endmodule
`default_nettype wire

### src/bbc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_back
// Stack engine: pushes and pops bracket kinds one item a cycle (a string end
// waits on an unsent verdict) and registers verdicts for the result channel.
// ----------------------------------------------------------------------------
module bbc_back #(
    parameter int STACK_DEPTH = 64
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               q_valid,
    output logic              q_ready,
    input  bbc_pkg::item_t    q_item,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [7:0]        m_tdata    // [1:0] verdict, [7:2] zero
);
    import bbc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

    // Top of stack lives in a register; the entry below it is read ahead
    logic [1:0]    stack_mem [STACK_DEPTH];
    logic [LW-1:0] level_reg, level_next;
    kind_t         top_reg, top_next;
    logic [1:0]    below_reg;
    logic          mismatch_reg, mismatch_next;
    logic          overflow_reg, overflow_next;
    logic          m_tvalid_reg, m_tvalid_next;
    verdict_t      verdict_reg, verdict_next;

    logic          consume;
    logic          active;
    logic          do_push;
    logic          do_pop;
    logic [LW-1:0] after_level;
    logic          after_mismatch;
    logic          after_overflow;
    logic [LW-1:0] rd_level;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;

    assign q_ready = !q_item.last || !m_tvalid_reg || m_tready;
    assign consume = q_valid && q_ready;
    assign active  = consume && q_item.is_bracket && !mismatch_reg && !overflow_reg;
    assign do_pop  = active && q_item.closing && (level_reg != '0) && (top_reg == q_item.kind);
    assign do_push = active && !q_item.closing && (level_reg != LEVEL_FULL);

    always_comb begin
        after_level    = level_reg;
        after_mismatch = mismatch_reg;
        after_overflow = overflow_reg;
        top_next       = top_reg;
        if (do_pop) begin
            after_level = level_reg - LW'(1);
            top_next    = kind_t'(below_reg);
        end else if (do_push) begin
            after_level = level_reg + LW'(1);
            top_next    = q_item.kind;
        end else if (active && q_item.closing) begin
            after_mismatch = 1'b1;
        end else if (active) begin
            after_overflow = 1'b1;
        end

        verdict_next  = verdict_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        level_next    = after_level;
        mismatch_next = after_mismatch;
        overflow_next = after_overflow;
        if (consume && q_item.last) begin
            if (after_mismatch) begin
                verdict_next = VERDICT_UNBALANCED;
            end else if (after_overflow) begin
                verdict_next = VERDICT_OVERFLOW;
            end else if (after_level == '0) begin
                verdict_next = VERDICT_BALANCED;
            end else begin
                verdict_next = VERDICT_UNBALANCED;
            end
            m_tvalid_next = 1'b1;
            level_next    = '0;
            mismatch_next = 1'b0;
            overflow_next = 1'b0;
        end
    end

    // Entry below the new top; garbage when fewer than two entries remain
    assign rd_level = level_next - LW'(2);
    assign rd_addr  = rd_level[AW-1:0];
    assign wr_addr  = level_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            stack_mem[wr_addr] <= q_item.kind;
        end
        below_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= '0;
            mismatch_reg <= 1'b0;
            overflow_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            level_reg    <= level_next;
            mismatch_reg <= mismatch_next;
            overflow_reg <= overflow_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        verdict_reg <= verdict_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, verdict_reg};

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mismatch_reg && overflow_reg))
        else $error("mismatch and overflow both set");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (level_reg == LEVEL_FULL))
        else $error("overflow flagged below full depth");

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LEVEL_FULL)
        else $error("stack level beyond depth");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && q_item.last) |=>
            (level_reg == '0) && !mismatch_reg && !overflow_reg && m_tvalid_reg)
        else $error("string end did not clear state");

endmodule
`default_nettype wire

### src/bracket_balance_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks that the brackets { } [ ] ( ) of a byte stream nest correctly.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one text byte per transaction in s_tdata, s_tlast high on
//   the final byte of a string. Other bytes than brackets are ignored.
//   m_ channel: one verdict per string, sent after its final byte:
//   0 unbalanced, 1 balanced, 2 nesting deeper than STACK_DEPTH.
//   The final byte is registered into the queue, then passes through the
//   stack engine into the output register, where its verdict is valid.
//   Throughput: one byte per cycle while s_tready is high; the stack
//   engine pushes or pops once a cycle unless held at a string end, with
//   the top in a register and the entry below read ahead from stack memory.
//   A two-entry queue separates input acceptance from the stack engine.
//   While the receiver stalls, the engine keeps consuming bytes until it
//   reaches the next string end, then holds; the queue then fills and
//   s_tready drops.
//   Reset empties the queue, clears the stack level and flags and drops
//   m_tvalid. No clearing pass is needed; data read ahead from entries
//   that have not been written is never used.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] char_code
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata    // [1:0] verdict, [7:2] zero
);
    import bbc_pkg::*;

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    bbc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

### dv/tb_bracket_balance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_balance_checker
// Self-checking bench for the bracket balance checker. A short table of
// directed strings covers every bracket, the byte extremes, closes on an
// empty stack or of the wrong kind, a full stack and a push past it. Random
// strings follow: mostly well nested with filler bytes, some broken, some
// pure noise, a few climbing to the stack limit. Every verdict is compared with
// the table's value on typed rows, else with a predictor that tracks its own stack,
// while both sides stall at random and the receiver once holds off for long.
// ----------------------------------------------------------------------------
module tb_bracket_balance_checker;

    import bbc_pkg::*;

    localparam int          DEPTH        = 64;
    localparam int unsigned RANDOM_ITEMS = 1350;  // total bytes, directed ones included
    localparam int unsigned STALL_AFTER  = 25;    // verdicts taken before the long hold-off
    localparam int unsigned LONG_STALL   = 300;
    localparam int unsigned IDLE_LIMIT   = 2000;  // cycles with no transaction on either side
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] reps;
        logic       last;
        logic       typed;
        verdict_t   want;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       typed;
        verdict_t   want;
    } text_byte_t;

    // last applies to the final repetition of a row only
    localparam dir_row_t DIRECTED [22] = '{
        '{8'h00,              8'd1,      1'b1, 1'b1, VERDICT_BALANCED},
        '{8'hFF,              8'd1,      1'b1, 1'b1, VERDICT_BALANCED},
        '{CHAR_BRACE_OPEN,    8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_SQUARE_OPEN,   8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_ROUND_OPEN,    8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{8'h41,              8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_ROUND_CLOSE,   8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_SQUARE_CLOSE,  8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_BRACE_CLOSE,   8'd1,      1'b1, 1'b1, VERDICT_BALANCED},
        // close on an empty stack, then an open that must be ignored
        '{CHAR_ROUND_CLOSE,   8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_ROUND_OPEN,    8'd1,      1'b1, 1'b1, VERDICT_UNBALANCED},
        // close of the wrong kind
        '{CHAR_SQUARE_OPEN,   8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_BRACE_CLOSE,   8'd1,      1'b1, 1'b1, VERDICT_UNBALANCED},
        // open on the final byte leaves the stack non-empty
        '{CHAR_BRACE_OPEN,    8'd1,      1'b1, 1'b1, VERDICT_UNBALANCED},
        // fill the stack, push once more, then a close that must be ignored
        '{CHAR_ROUND_OPEN,    8'(DEPTH), 1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_SQUARE_OPEN,   8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_ROUND_CLOSE,   8'd1,      1'b1, 1'b1, VERDICT_OVERFLOW},
        // exactly full, then emptied again
        '{CHAR_SQUARE_OPEN,   8'(DEPTH), 1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_SQUARE_CLOSE,  8'(DEPTH), 1'b1, 1'b0, VERDICT_UNBALANCED},
        // close on an empty stack as the final byte
        '{CHAR_SQUARE_CLOSE,  8'd1,      1'b1, 1'b1, VERDICT_UNBALANCED},
        '{CHAR_BRACE_OPEN,    8'd1,      1'b0, 1'b0, VERDICT_UNBALANCED},
        '{CHAR_BRACE_CLOSE,   8'd1,      1'b1, 1'b0, VERDICT_UNBALANCED}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] char_code
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [1:0] verdict, [7:2] zero

    text_byte_t  text_q [$];
    verdict_t    verdicts_due [$];

    // predictor state
    kind_t       pred_stack [DEPTH];
    int unsigned pred_level;
    bit          pred_mismatch;
    bit          pred_overflow;
    int unsigned pred_peak;
    int unsigned verdict_tally [3];

    int unsigned mismatches;
    int unsigned verdicts_checked;
    int unsigned bytes_sent;
    int unsigned stalled_cycles;

    bracket_balance_checker #(
        .STACK_DEPTH(DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic kind_t bracket_kind(input logic [7:0] c, output bit closing);
        closing = 1'b0;
        case (c)
            CHAR_BRACE_OPEN:   return KIND_BRACE;
            CHAR_SQUARE_OPEN:  return KIND_SQUARE;
            CHAR_ROUND_OPEN:   return KIND_ROUND;
            CHAR_BRACE_CLOSE: begin
                closing = 1'b1;
                return KIND_BRACE;
            end
            CHAR_SQUARE_CLOSE: begin
                closing = 1'b1;
                return KIND_SQUARE;
            end
            CHAR_ROUND_CLOSE: begin
                closing = 1'b1;
                return KIND_ROUND;
            end
            default:           return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] bracket_char(input kind_t k, input bit closing);
        case (k)
            KIND_BRACE:  return closing ? CHAR_BRACE_CLOSE : CHAR_BRACE_OPEN;
            KIND_SQUARE: return closing ? CHAR_SQUARE_CLOSE : CHAR_SQUARE_OPEN;
            default:     return closing ? CHAR_ROUND_CLOSE : CHAR_ROUND_OPEN;
        endcase
    endfunction

    // Advance the predicted stack by one byte; return 1 when a verdict is due.
    function automatic bit predict_verdict(input logic [7:0] c, input bit fin,
                                           output verdict_t v);
        bit    closing;
        kind_t k;
        k = bracket_kind(c, closing);
        v = VERDICT_UNBALANCED;
        if (k != KIND_NONE && !pred_mismatch && !pred_overflow) begin
            if (closing) begin
                if (pred_level > 0 && pred_stack[pred_level - 1] == k)
                    pred_level--;
                else
                    pred_mismatch = 1'b1;
            end else if (pred_level < DEPTH) begin
                pred_stack[pred_level] = k;
                pred_level++;
                if (pred_level > pred_peak)
                    pred_peak = pred_level;
            end else begin
                pred_overflow = 1'b1;
            end
        end
        if (!fin)
            return 1'b0;
        if (pred_mismatch)
            v = VERDICT_UNBALANCED;
        else if (pred_overflow)
            v = VERDICT_OVERFLOW;
        else
            v = (pred_level == 0) ? VERDICT_BALANCED : VERDICT_UNBALANCED;
        pred_level    = 0;
        pred_mismatch = 1'b0;
        pred_overflow = 1'b0;
        return 1'b1;
    endfunction

    // Random wait, with calm stretches of back-to-back transactions
    function automatic int unsigned pick_gap(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Queue one byte; return 1 if the block does anything with it
    function automatic int unsigned add_byte(input logic [7:0] c, input bit fin,
                                             input bit typed, input verdict_t want);
        bit closing;
        text_q.push_back('{code: c, last: fin, typed: typed, want: want});
        return (fin || bracket_kind(c, closing) != KIND_NONE) ? 1 : 0;
    endfunction

    function automatic int unsigned add_random_string();
        logic [7:0]  text [$];
        kind_t       open_kinds [$];
        int unsigned cap, steps, r, pos, useful;
        kind_t       k;
        useful = 0;
        if ($urandom_range(0, 9) == 0) begin
            // noise, rich in bracket bytes
            steps = $urandom_range(1, 16);
            repeat (steps) begin
                if ($urandom_range(0, 1) == 0)
                    text.push_back(bracket_char(kind_t'($urandom_range(0, 2)),
                                                1'($urandom_range(0, 1))));
                else
                    text.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            if ($urandom_range(0, 29) == 0) begin
                // climb to the stack limit, sometimes a little past it
                cap = $urandom_range(DEPTH - 2, DEPTH + 2);
                repeat (cap) begin
                    k = kind_t'($urandom_range(0, 2));
                    open_kinds.push_back(k);
                    text.push_back(bracket_char(k, 1'b0));
                end
            end else begin
                cap   = $urandom_range(1, 6);
                steps = $urandom_range(0, 3 * cap + 4);
                repeat (steps) begin
                    r = $urandom_range(0, 9);
                    if (r < 2) begin
                        text.push_back(8'($urandom_range(0, 255)));
                    end else if (open_kinds.size() == 0 ||
                                 (r < 6 && open_kinds.size() < cap)) begin
                        k = kind_t'($urandom_range(0, 2));
                        open_kinds.push_back(k);
                        text.push_back(bracket_char(k, 1'b0));
                    end else begin
                        text.push_back(bracket_char(open_kinds.pop_back(), 1'b1));
                    end
                end
            end
            while (open_kinds.size() != 0)
                text.push_back(bracket_char(open_kinds.pop_back(), 1'b1));
            if (text.size() == 0)
                text.push_back(8'($urandom_range(0, 255)));
            // break some sequences: swap a bracket, drop a byte or add a close
            if ($urandom_range(0, 9) < 3) begin
                pos = $urandom_range(0, text.size() - 1);
                case ($urandom_range(0, 2))
                    0: text[pos] = bracket_char(kind_t'($urandom_range(0, 2)),
                                                1'($urandom_range(0, 1)));
                    1: if (text.size() > 1) text.delete(pos);
                    default: text.push_back(bracket_char(kind_t'($urandom_range(0, 2)),
                                                         1'b1));
                endcase
            end
        end
        foreach (text[i])
            useful += add_byte(text[i], i == text.size() - 1, 1'b0, VERDICT_UNBALANCED);
        return useful;
    endfunction

    // Verdict checker
    always @(posedge aclk) begin : verdict_check
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                $display("%0t: verdict with none expected, expected none, actual %0d",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                if (m_tdata[1:0] !== want) begin
                    $display("%0t: verdict mismatch, expected %0d, actual %0d",
                             $time, want, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[7:2] !== 6'd0) begin
                    $display("%0t: tdata padding mismatch, expected 0, actual %0d",
                             $time, m_tdata[7:2]);
                    mismatches++;
                end
            end
            verdicts_checked++;
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles <= 0;
        end else if (aresetn) begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d verdicts outstanding",
                         $time, IDLE_LIMIT, verdicts_due.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Verdict receiver
    initial begin : verdict_sink
        int unsigned calm, gap, taken;
        calm  = 0;
        taken = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            gap = pick_gap(calm);
            // hold off long enough for the block to fill and stall its input
            if (taken == STALL_AFTER)
                gap = LONG_STALL;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            taken++;
        end
    end

    // Reset, stimulus and end of run
    initial begin : text_source
        int unsigned calm, gap;
        verdict_t    v;
        aresetn        <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'd0;
        s_tlast        <= 1'b0;
        stalled_cycles  = 0;
        mismatches      = 0;
        verdicts_checked = 0;
        bytes_sent      = 0;
        pred_level      = 0;
        pred_mismatch   = 1'b0;
        pred_overflow   = 1'b0;
        pred_peak       = 0;
        calm            = 0;
        foreach (verdict_tally[i])
            verdict_tally[i] = 0;

        foreach (DIRECTED[r])
            for (int n = 0; n < DIRECTED[r].reps; n++)
                void'(add_byte(DIRECTED[r].code, DIRECTED[r].last && n == DIRECTED[r].reps - 1,
                               DIRECTED[r].typed, DIRECTED[r].want));
        while (text_q.size() < RANDOM_ITEMS)
            void'(add_random_string());

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (text_q[i]) begin
            gap = pick_gap(calm);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i].code;
            s_tlast  <= text_q[i].last;
            do @(posedge aclk); while (s_tready !== 1'b1);
            bytes_sent++;
            if (predict_verdict(text_q[i].code, text_q[i].last, v)) begin
                verdict_tally[v]++;
                verdicts_due.push_back(text_q[i].typed ? text_q[i].want : v);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes in %0d strings: %0d balanced, %0d unbalanced, %0d too deep",
                 bytes_sent, verdicts_checked, verdict_tally[VERDICT_BALANCED],
                 verdict_tally[VERDICT_UNBALANCED], verdict_tally[VERDICT_OVERFLOW]);
        $display("Deepest nesting reached %0d of %0d, %0d mismatches",
                 pred_peak, DEPTH, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
